@@ hw/rtl/eat_pkg.sv @@
// ----------------------------------------------------------------------------
// eat_pkg
// Shared types and constants for the expiring address table.
// ----------------------------------------------------------------------------
`default_nettype none

package eat_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_SAME = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic        is_v6;
      logic [63:0] addr_upper;
      logic [63:0] addr_lower;
      logic [31:0] end_seconds;
   } entry_type;

   typedef struct packed {
      logic    load;
      logic    rd_en;
      idx_type rd_idx;
      logic    cmp_en;
      idx_type cmp_idx;
      logic    finish;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

@@ hw/rtl/eat_if.sv @@
// ----------------------------------------------------------------------------
// eat_if
// Valid/ready channels for request and response words of the address table.
// ----------------------------------------------------------------------------
`default_nettype none

interface eat_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic        is_v6;
   logic [63:0] addr_upper;
   logic [63:0] addr_lower;
   logic [31:0] end_seconds;
   logic [31:0] now_seconds;

   modport source (output valid, command, is_v6, addr_upper, addr_lower,
                   end_seconds, now_seconds, input ready);
   modport sink   (input valid, command, is_v6, addr_upper, addr_lower,
                   end_seconds, now_seconds, output ready);
endinterface

interface eat_rsp_if;
   logic       valid;
   logic       ready;
   logic       addr_free;
   logic [1:0] status;

   modport source (output valid, addr_free, status, input ready);
   modport sink   (input valid, addr_free, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/eat_ctrl.sv @@
// ----------------------------------------------------------------------------
// eat_ctrl
// Sequencer: accepts a request word, sweeps the table, commits, responds.
// ----------------------------------------------------------------------------
`default_nettype none

module eat_ctrl
   import eat_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output ctrl_cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_FINISH = 3'd3;
   localparam logic [2:0] ST_RESP   = 3'd4;

   localparam idx_type LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   logic [2:0] state_ff, state_in;
   idx_type    rd_idx_ff, rd_idx_in;
   logic       cmp_en_ff, cmp_en_in;
   idx_type    cmp_idx_ff, cmp_idx_in;

   always_comb begin
      state_in   = state_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_en_in  = 1'b0;
      cmp_idx_in = rd_idx_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            rd_idx_in = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one entry read per cycle; the compare follows in the next cycle
            cmd.rd_en  = 1'b1;
            cmd.rd_idx = rd_idx_ff;
            cmp_en_in  = 1'b1;
            rd_idx_in  = rd_idx_ff + 1'b1;
            if (rd_idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.cmp_en  = cmp_en_ff;
      cmd.cmp_idx = cmp_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_idx_ff <= '0;
         cmp_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_idx_ff <= rd_idx_in;
         cmp_en_ff <= cmp_en_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= cmp_idx_in;
   end

endmodule

`default_nettype wire

@@ hw/rtl/eat_dp.sv @@
// ----------------------------------------------------------------------------
// eat_dp
// Datapath: request register, entry memory, valid bits, compare and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module eat_dp
   import eat_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire ctrl_cmd_type  cmd,
   input  wire logic          req_command,
   input  wire logic          req_is_v6,
   input  wire logic [63:0]   req_addr_upper,
   input  wire logic [63:0]   req_addr_lower,
   input  wire logic [31:0]   req_end_seconds,
   input  wire logic [31:0]   req_now_seconds,
   output logic               rsp_addr_free,
   output logic [1:0]         rsp_status
);

   // request word, address normalized so IPv4 keeps only bits 31..0
   logic        item_cmd_ff;
   entry_type   item_ff;
   logic [31:0] item_now_ff;

   entry_type   mem [TABLE_ENTRIES];
   entry_type   rd_data_ff;

   logic [TABLE_ENTRIES-1:0] valid_ff;

   logic    match_fnd_ff, match_fnd_in;
   idx_type match_idx_ff, match_idx_in;
   logic    match_same_ff, match_same_in;
   logic    free_fnd_ff, free_fnd_in;
   idx_type free_idx_ff, free_idx_in;

   logic    ent_valid, ent_expired, ent_live, ent_hit, purge;
   logic    wr_en, set_valid;
   idx_type wr_idx;
   logic    free_out_in;
   logic [1:0] status_in;
   logic    free_out_ff;
   logic [1:0] status_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_cmd_ff          <= req_command;
         item_ff.is_v6        <= req_is_v6;
         item_ff.addr_upper   <= req_is_v6 ? req_addr_upper : 64'd0;
         item_ff.addr_lower   <= req_is_v6 ? req_addr_lower
                                           : {32'd0, req_addr_lower[31:0]};
         item_ff.end_seconds  <= req_end_seconds;
         item_now_ff          <= req_now_seconds;
      end
   end

   // compare stage on the entry read last cycle
   always_comb begin
      ent_valid   = valid_ff[cmd.cmp_idx];
      ent_expired = (rd_data_ff.end_seconds != 32'd0)
                 && (rd_data_ff.end_seconds < item_now_ff);
      purge       = cmd.cmp_en && (item_cmd_ff == CMD_CHECK) && ent_valid && ent_expired;
      ent_live    = ent_valid && !((item_cmd_ff == CMD_CHECK) && ent_expired);
      ent_hit     = ent_live
                 && (rd_data_ff.is_v6 == item_ff.is_v6)
                 && (rd_data_ff.addr_upper == item_ff.addr_upper)
                 && (rd_data_ff.addr_lower == item_ff.addr_lower);

      match_fnd_in  = match_fnd_ff;
      match_idx_in  = match_idx_ff;
      match_same_in = match_same_ff;
      free_fnd_in   = free_fnd_ff;
      free_idx_in   = free_idx_ff;
      if (cmd.load) begin
         match_fnd_in = 1'b0;
         free_fnd_in  = 1'b0;
      end else if (cmd.cmp_en) begin
         if (ent_hit && !match_fnd_ff) begin
            match_fnd_in  = 1'b1;
            match_idx_in  = cmd.cmp_idx;
            match_same_in = (rd_data_ff.end_seconds == item_ff.end_seconds);
         end
         if (!ent_valid && !free_fnd_ff) begin
            free_fnd_in = 1'b1;
            free_idx_in = cmd.cmp_idx;
         end
      end
   end

   // commit: decide the response and the single table write
   always_comb begin
      wr_en       = 1'b0;
      set_valid   = 1'b0;
      wr_idx      = match_idx_ff;
      free_out_in = 1'b0;
      status_in   = STATUS_OK;
      if (item_cmd_ff == CMD_CHECK) begin
         free_out_in = !match_fnd_ff;
      end else if (match_fnd_ff) begin
         if (match_same_ff) begin
            status_in = STATUS_SAME;
         end else begin
            wr_en = cmd.finish;
         end
      end else if (free_fnd_ff) begin
         wr_en     = cmd.finish;
         set_valid = cmd.finish;
         wr_idx    = free_idx_ff;
      end else begin
         status_in = STATUS_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= item_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (purge) begin
            valid_ff[cmd.cmp_idx] <= 1'b0;
         end
         if (set_valid) begin
            valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      match_fnd_ff  <= match_fnd_in;
      match_idx_ff  <= match_idx_in;
      match_same_ff <= match_same_in;
      free_fnd_ff   <= free_fnd_in;
      free_idx_ff   <= free_idx_in;
      if (cmd.finish) begin
         free_out_ff <= free_out_in;
         status_ff   <= status_in;
      end
   end

   assign rsp_addr_free = free_out_ff;
   assign rsp_status    = status_ff;

endmodule

`default_nettype wire

@@ hw/rtl/expiring_address_table_unit.sv @@
// ----------------------------------------------------------------------------
// expiring_address_table_unit
// Table of in-use multicast addresses with end times: store and check.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   req_if    in    valid/ready    command, is_v6, addr_upper, addr_lower,
//                                  end_seconds, now_seconds
//   rsp_if    out   valid/ready    addr_free, status
//
// After acceptance, a request word runs through the sweep, which reads one
// entry of the entry memory per cycle, then through the compare (DRAIN) and
// commit (FINISH) states, before rsp valid rises.
// Reset clears the valid bits at once; there is no clearing pass.
// req ready stays low from acceptance until the response word is taken;
// the response word holds while rsp ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module expiring_address_table_unit
   import eat_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   eat_req_if.sink    req_if,
   eat_rsp_if.source  rsp_if
);

   ctrl_cmd_type cmd;

   eat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd)
   );

   eat_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_command     (req_if.command),
      .req_is_v6       (req_if.is_v6),
      .req_addr_upper  (req_if.addr_upper),
      .req_addr_lower  (req_if.addr_lower),
      .req_end_seconds (req_if.end_seconds),
      .req_now_seconds (req_if.now_seconds),
      .rsp_addr_free   (rsp_if.addr_free),
      .rsp_status      (rsp_if.status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request accepted while previous word in flight");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request side open while response pending");

   a_finish_to_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (rsp_if.valid && !req_if.ready))
      else $error("commit not followed by response");

   a_free_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.addr_free) |-> (rsp_if.status == STATUS_OK))
      else $error("free address reported with non-ok status");

endmodule

`default_nettype wire
